// ===== sv/c6502_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c6502_pkg
// Shared types and constants for the 6502-style register and ALU execute
// block: instruction kinds, decoded micro-operation fields and flag positions.
// ----------------------------------------------------------------------------
package c6502_pkg;

  // Instruction kinds as they arrive on the input channel.
  typedef enum logic [4:0] {
    KIND_LDA = 5'd0,
    KIND_LDX = 5'd1,
    KIND_LDY = 5'd2,
    KIND_STA = 5'd3,
    KIND_STX = 5'd4,
    KIND_STY = 5'd5,
    KIND_TAX = 5'd6,
    KIND_TXA = 5'd7,
    KIND_TAY = 5'd8,
    KIND_TYA = 5'd9,
    KIND_ADC = 5'd10,
    KIND_SBC = 5'd11,
    KIND_INC = 5'd12,
    KIND_INX = 5'd13,
    KIND_INY = 5'd14,
    KIND_DEC = 5'd15,
    KIND_DEX = 5'd16,
    KIND_DEY = 5'd17
  } kind_e;

  // Source of the value that goes through the ALU.
  typedef enum logic [1:0] {
    SRC_MEM,
    SRC_A,
    SRC_X,
    SRC_Y
  } src_e;

  // ALU operation.
  typedef enum logic [2:0] {
    ALU_PASS,
    ALU_INC,
    ALU_DEC,
    ALU_ADC,
    ALU_SBC
  } alu_e;

  // Destination of the ALU result.
  typedef enum logic [2:0] {
    DST_NONE,
    DST_A,
    DST_X,
    DST_Y,
    DST_MEM
  } dst_e;

  // One decoded instruction as it travels from the front to the back.
  typedef struct packed {
    src_e       src;
    alu_e       alu;
    dst_e       dst;
    logic       set_nz;
    logic       set_cv;
    logic [7:0] operand;
  } uop_t;

  // Bit positions in the status byte.
  localparam int unsigned FLAG_C = 0;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_V = 6;
  localparam int unsigned FLAG_N = 7;

  // Depth of the queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

endpackage

// ===== sv/c6502_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c6502_front
// Accepts instruction transactions and classifies each kind into a micro-op
// that names the ALU source, the operation, the destination and the flags.
// ----------------------------------------------------------------------------
module c6502_front (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [4:0]        kind_i,
  input  logic [7:0]        operand_i,
  input  logic              full_i,
  output logic              push_o,
  output c6502_pkg::uop_t   uop_o
);
  import c6502_pkg::*;

  // The queue is the only thing that can hold the front back.
  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  // Classify the instruction kind.
  always_comb begin
    uop_o         = '0;
    uop_o.src     = SRC_MEM;
    uop_o.alu     = ALU_PASS;
    uop_o.dst     = DST_NONE;
    uop_o.set_nz  = 1'b0;
    uop_o.set_cv  = 1'b0;
    uop_o.operand = operand_i;
    case (kind_e'(kind_i))
      KIND_LDA: begin uop_o.dst = DST_A; uop_o.set_nz = 1'b1; end
      KIND_LDX: begin uop_o.dst = DST_X; uop_o.set_nz = 1'b1; end
      KIND_LDY: begin uop_o.dst = DST_Y; uop_o.set_nz = 1'b1; end
      KIND_STA: begin uop_o.src = SRC_A; uop_o.dst = DST_MEM; end
      KIND_STX: begin uop_o.src = SRC_X; uop_o.dst = DST_MEM; end
      KIND_STY: begin uop_o.src = SRC_Y; uop_o.dst = DST_MEM; end
      KIND_TAX: begin uop_o.src = SRC_A; uop_o.dst = DST_X; uop_o.set_nz = 1'b1; end
      KIND_TXA: begin uop_o.src = SRC_X; uop_o.dst = DST_A; uop_o.set_nz = 1'b1; end
      KIND_TAY: begin uop_o.src = SRC_A; uop_o.dst = DST_Y; uop_o.set_nz = 1'b1; end
      KIND_TYA: begin uop_o.src = SRC_Y; uop_o.dst = DST_A; uop_o.set_nz = 1'b1; end
      KIND_ADC: begin
        uop_o.alu    = ALU_ADC;
        uop_o.dst    = DST_A;
        uop_o.set_nz = 1'b1;
        uop_o.set_cv = 1'b1;
      end
      KIND_SBC: begin
        uop_o.alu    = ALU_SBC;
        uop_o.dst    = DST_A;
        uop_o.set_nz = 1'b1;
        uop_o.set_cv = 1'b1;
      end
      KIND_INC: begin uop_o.alu = ALU_INC; uop_o.dst = DST_MEM; uop_o.set_nz = 1'b1; end
      KIND_INX: begin
        uop_o.src = SRC_X; uop_o.alu = ALU_INC; uop_o.dst = DST_X; uop_o.set_nz = 1'b1;
      end
      KIND_INY: begin
        uop_o.src = SRC_Y; uop_o.alu = ALU_INC; uop_o.dst = DST_Y; uop_o.set_nz = 1'b1;
      end
      KIND_DEC: begin uop_o.alu = ALU_DEC; uop_o.dst = DST_MEM; uop_o.set_nz = 1'b1; end
      KIND_DEX: begin
        uop_o.src = SRC_X; uop_o.alu = ALU_DEC; uop_o.dst = DST_X; uop_o.set_nz = 1'b1;
      end
      KIND_DEY: begin
        uop_o.src = SRC_Y; uop_o.alu = ALU_DEC; uop_o.dst = DST_Y; uop_o.set_nz = 1'b1;
      end
      default: begin
        // Unused kinds leave everything as it is.
        uop_o.dst = DST_NONE;
      end
    endcase
  end

endmodule

// ===== sv/c6502_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c6502_queue
// Short first-in first-out queue of decoded micro-ops between the front and
// the back, so that each side can stall without holding up the other.
// ----------------------------------------------------------------------------
module c6502_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  c6502_pkg::uop_t   push_uop_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output c6502_pkg::uop_t   pop_uop_o
);
  import c6502_pkg::*;

  uop_t                   entries_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0] count_q, count_d;
  logic                   do_push, do_pop;

  assign full_o    = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign empty_o   = (count_q == '0);
  assign pop_uop_o = entries_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_uop_i;
    end
  end

endmodule

// ===== sv/c6502_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c6502_back
// Carries out one micro-op per cycle, while the output is not stalled, against
// the A, X, Y and status registers; holds the result in an output register.
// ----------------------------------------------------------------------------
module c6502_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  c6502_pkg::uop_t   uop_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        acc_o,
  output logic [7:0]        index_x_o,
  output logic [7:0]        index_y_o,
  output logic [7:0]        status_o,
  output logic              mem_write_o,
  output logic [7:0]        mem_data_o
);
  import c6502_pkg::*;

  logic       out_valid_q, out_valid_d;
  logic [7:0] acc_q, acc_d;
  logic [7:0] x_q, x_d;
  logic [7:0] y_q, y_d;
  logic [7:0] status_q, status_d;
  logic       mem_write_q, mem_write_d;
  logic [7:0] mem_data_q, mem_data_d;

  logic [7:0] src_val;
  logic [7:0] add_m;
  logic [8:0] sum;
  logic [7:0] res;
  logic       ovf;

  // Take the next micro-op whenever the output register is free or drains.
  assign pop_o = !empty_i && (!out_valid_q || !out_stall_i);

  // ALU source selection.
  always_comb begin
    case (uop_i.src)
      SRC_MEM: src_val = uop_i.operand;
      SRC_A:   src_val = acc_q;
      SRC_X:   src_val = x_q;
      SRC_Y:   src_val = y_q;
      default: src_val = uop_i.operand;
    endcase
  end

  // Nine-bit add for ADC and SBC; SBC adds the inverted operand.
  assign add_m = (uop_i.alu == ALU_SBC) ? ~uop_i.operand : uop_i.operand;
  assign sum   = {1'b0, acc_q} + {1'b0, add_m} + {8'd0, status_q[FLAG_C]};
  assign ovf   = ~(acc_q[7] ^ add_m[7]) & (acc_q[7] ^ sum[7]);

  // ALU result.
  always_comb begin
    case (uop_i.alu)
      ALU_PASS: res = src_val;
      ALU_INC:  res = src_val + 8'd1;
      ALU_DEC:  res = src_val - 8'd1;
      ALU_ADC:  res = sum[7:0];
      ALU_SBC:  res = sum[7:0];
      default:  res = src_val;
    endcase
  end

  // Register, flag and output updates.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    acc_d       = acc_q;
    x_d         = x_q;
    y_d         = y_q;
    status_d    = status_q;
    mem_write_d = mem_write_q;
    mem_data_d  = mem_data_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
      mem_write_d = 1'b0;
      mem_data_d  = 8'd0;
      case (uop_i.dst)
        DST_A:   acc_d = res;
        DST_X:   x_d   = res;
        DST_Y:   y_d   = res;
        DST_MEM: begin
          mem_write_d = 1'b1;
          mem_data_d  = res;
        end
        default: begin
        end
      endcase
      if (uop_i.set_nz) begin
        status_d[FLAG_Z] = (res == 8'd0);
        status_d[FLAG_N] = res[7];
      end
      if (uop_i.set_cv) begin
        status_d[FLAG_C] = sum[8];
        status_d[FLAG_V] = ovf;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      acc_q       <= 8'd0;
      x_q         <= 8'd0;
      y_q         <= 8'd0;
      status_q    <= 8'd0;
      mem_write_q <= 1'b0;
      mem_data_q  <= 8'd0;
    end else begin
      out_valid_q <= out_valid_d;
      acc_q       <= acc_d;
      x_q         <= x_d;
      y_q         <= y_d;
      status_q    <= status_d;
      mem_write_q <= mem_write_d;
      mem_data_q  <= mem_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign acc_o       = acc_q;
  assign index_x_o   = x_q;
  assign index_y_o   = y_q;
  assign status_o    = status_q;
  assign mem_write_o = mem_write_q;
  assign mem_data_o  = mem_data_q;

  // A micro-op taken from the queue always shows up as a result.
  a_pop_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_valid_q)
    else $error("micro-op popped without producing a result");

  // The status bits between C, Z and V, N are never set.
  a_unused_flags_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_q[5:2] == 4'd0)
    else $error("unused status bits set");

  // Without a write request the data byte reads zero.
  a_no_write_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !mem_write_q |-> (mem_data_q == 8'd0))
    else $error("memory data nonzero without write request");

  // Registers change only when a new result is loaded.
  a_regs_hold_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pop_o |=> $stable(acc_q) && $stable(x_q) && $stable(y_q) && $stable(status_q))
    else $error("architectural register changed without a micro-op");

endmodule

// ===== sv/cpu6502_register_alu_execute_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu6502_register_alu_execute_core
// Execute stage of a 6502-style core without decimal mode: loads, stores,
// transfers, ADC, SBC and increment/decrement, with A, X, Y and N/V/Z/C.
// ----------------------------------------------------------------------------
// The block takes one instruction transaction per cycle while the queue is
// not full and gives one result transaction for each, in order. An accepted
// instruction is decoded and written into the two-entry queue, and the back
// executes it from there into the output register, one micro-op per cycle
// while the output is not stalled. The rate of one per cycle is set by the
// combinational 8-bit ALU that reads and writes the A, X, Y and status
// registers in the same cycle. Each result shows the registers after its
// instruction plus any memory write request; a stalled output keeps
// accepting input until the queue is full.
module cpu6502_register_alu_execute_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [4:0] kind_i,
  input  logic [7:0] operand_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] acc_o,
  output logic [7:0] index_x_o,
  output logic [7:0] index_y_o,
  output logic [7:0] status_o,
  output logic       mem_write_o,
  output logic [7:0] mem_data_o
);
  import c6502_pkg::*;

  logic full;
  logic push;
  uop_t push_uop;
  logic empty;
  logic pop;
  uop_t pop_uop;

  // Decode side.
  c6502_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .operand_i  (operand_i),
    .full_i     (full),
    .push_o     (push),
    .uop_o      (push_uop)
  );

  // Queue between decode and execute.
  c6502_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_uop_i (push_uop),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .pop_uop_o  (pop_uop)
  );

  // Execute side with the register file and output register.
  c6502_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .uop_i       (pop_uop),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .acc_o       (acc_o),
    .index_x_o   (index_x_o),
    .index_y_o   (index_y_o),
    .status_o    (status_o),
    .mem_write_o (mem_write_o),
    .mem_data_o  (mem_data_o)
  );

endmodule
